[sv/tcsw_pkg.sv]
// Package for the text console scroll writer: widths, codes, states and defaults.
package tcsw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int DATA_W = 16;
  localparam int OROW_W = 5;
  localparam int OCOL_W = 7;

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;

  localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0] TEXT_ATTR  = 8'h07;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_PUT,
    ST_CLEAR,
    ST_READ,
    ST_FIN
  } state_e;

endpackage

[sv/text_console_scroll_writer_top.sv]
// Text console scroll writer top level: request sequencer around the screen store.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_ready_o    | req_type, char_code, cell_index
//  out     | output    | out_valid_o / out_ready_i  | cell_written, cell_addr, cell_data,
//          |           |                            | scrolled, cursor_row, cursor_col
//
// One request at a time. A put that scrolls first makes one sweep of the single write port
// over all ROWS*COLUMNS cells that copies rows up and blanks the last row. A clear sweeps
// every cell once, writing zero. After reset a clearing pass over every cell runs before
// in_ready_o rises. A result waits in the output register; the sequencer holds in its final
// state until that register is free.
module text_console_scroll_writer_top #(
  parameter int COLUMNS = tcsw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcsw_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcsw_pkg::REQ_W-1:0]    req_type_i,
  input  logic [tcsw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcsw_pkg::IDX_W-1:0]    cell_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          cell_written_o,
  output logic [tcsw_pkg::IDX_W-1:0]    cell_addr_o,
  output logic [tcsw_pkg::DATA_W-1:0]   cell_data_o,
  output logic                          scrolled_o,
  output logic [tcsw_pkg::OROW_W-1:0]   cursor_row_o,
  output logic [tcsw_pkg::OCOL_W-1:0]   cursor_col_o
);

  localparam int CELLS    = ROWS * COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int RW       = $clog2(ROWS + 1);
  localparam int CW       = $clog2(COLUMNS);
  localparam int COPY_END = (ROWS - 1) * COLUMNS;
  localparam int DW       = tcsw_pkg::DATA_W;
  localparam int IW       = tcsw_pkg::IDX_W;

  tcsw_pkg::state_e state_q, state_d;

  logic [AW-1:0] ctr_q, ctr_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;

  logic [tcsw_pkg::CHAR_W-1:0] ch_q, ch_d;
  logic [IW-1:0]               idx_q, idx_d;

  logic          res_written_q, res_written_d;
  logic          res_scrolled_q, res_scrolled_d;
  logic          res_rd_q, res_rd_d;
  logic          res_inrange_q, res_inrange_d;
  logic [IW-1:0] res_addr_q, res_addr_d;
  logic [DW-1:0] res_data_q, res_data_d;

  logic          wen_q, wen_d;
  logic          wcopy_q, wcopy_d;
  logic [AW-1:0] waddr_q, waddr_d;
  logic [DW-1:0] wdata_q, wdata_d;

  logic                        out_valid_q, out_valid_d;
  logic                        out_written_q, out_written_d;
  logic [IW-1:0]               out_addr_q, out_addr_d;
  logic [DW-1:0]               out_data_q, out_data_d;
  logic                        out_scrolled_q, out_scrolled_d;
  logic [tcsw_pkg::OROW_W-1:0] out_row_q, out_row_d;
  logic [tcsw_pkg::OCOL_W-1:0] out_col_q, out_col_d;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [DW-1:0] ram_wdata;

  logic [AW-1:0] put_addr;
  logic [CW:0]   col_inc;
  logic          sweep_last;

  assign ram_wdata  = wcopy_q ? ram_rdata : wdata_q;
  assign put_addr   = AW'(row_q * COLUMNS) + AW'(col_q);
  assign col_inc    = {1'b0, col_q} + (CW+1)'(1);
  assign sweep_last = (ctr_q == AW'(CELLS - 1));

  tcsw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (AW),
    .DATA_W (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wen_q),
    .waddr_i (waddr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d        = state_q;
    ctr_d          = ctr_q;
    row_d          = row_q;
    col_d          = col_q;
    ch_d           = ch_q;
    idx_d          = idx_q;
    res_written_d  = res_written_q;
    res_scrolled_d = res_scrolled_q;
    res_rd_d       = res_rd_q;
    res_inrange_d  = res_inrange_q;
    res_addr_d     = res_addr_q;
    res_data_d     = res_data_q;
    wen_d          = 1'b0;
    wcopy_d        = 1'b0;
    waddr_d        = waddr_q;
    wdata_d        = wdata_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_written_d  = out_written_q;
    out_addr_d     = out_addr_q;
    out_data_d     = out_data_q;
    out_scrolled_d = out_scrolled_q;
    out_row_d      = out_row_q;
    out_col_d      = out_col_q;
    ram_re         = 1'b0;
    ram_raddr      = ctr_q + AW'(COLUMNS);
    in_ready_o     = 1'b0;

    unique case (state_q)
      tcsw_pkg::ST_INIT, tcsw_pkg::ST_CLEAR: begin
        wen_d   = 1'b1;
        waddr_d = ctr_q;
        wdata_d = '0;
        ctr_d   = ctr_q + AW'(1);
        if (sweep_last) begin
          ctr_d   = '0;
          state_d = (state_q == tcsw_pkg::ST_INIT) ? tcsw_pkg::ST_IDLE : tcsw_pkg::ST_FIN;
        end
      end

      tcsw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ch_d           = char_code_i;
          idx_d          = cell_index_i;
          res_written_d  = 1'b0;
          res_scrolled_d = 1'b0;
          res_rd_d       = 1'b0;
          res_inrange_d  = 1'b0;
          res_addr_d     = '0;
          res_data_d     = '0;
          ctr_d          = '0;
          unique case (req_type_i)
            tcsw_pkg::REQ_PUT: begin
              state_d = (row_q >= RW'(ROWS)) ? tcsw_pkg::ST_SCROLL : tcsw_pkg::ST_PUT;
            end
            tcsw_pkg::REQ_CLEAR: begin
              row_d   = '0;
              state_d = tcsw_pkg::ST_CLEAR;
            end
            tcsw_pkg::REQ_READ: begin
              state_d = tcsw_pkg::ST_READ;
            end
            default: begin
              state_d = tcsw_pkg::ST_FIN;
            end
          endcase
        end
      end

      tcsw_pkg::ST_SCROLL: begin
        wen_d   = 1'b1;
        waddr_d = ctr_q;
        if (ctr_q < AW'(COPY_END)) begin
          ram_re  = 1'b1;
          wcopy_d = 1'b1;
        end else begin
          wdata_d = tcsw_pkg::BLANK_CELL;
        end
        ctr_d = ctr_q + AW'(1);
        if (sweep_last) begin
          ctr_d          = '0;
          row_d          = RW'(ROWS - 1);
          res_scrolled_d = 1'b1;
          state_d        = tcsw_pkg::ST_PUT;
        end
      end

      tcsw_pkg::ST_PUT: begin
        if (ch_q == tcsw_pkg::CH_NEWLINE) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else if (ch_q != tcsw_pkg::CH_RETURN) begin
          wen_d         = 1'b1;
          waddr_d       = put_addr;
          wdata_d       = {tcsw_pkg::TEXT_ATTR, ch_q};
          res_written_d = 1'b1;
          res_addr_d    = IW'(put_addr);
          res_data_d    = {tcsw_pkg::TEXT_ATTR, ch_q};
          if (col_inc >= (CW+1)'(COLUMNS)) begin
            col_d = '0;
            row_d = row_q + RW'(1);
          end else begin
            col_d = col_inc[CW-1:0];
          end
        end
        state_d = tcsw_pkg::ST_FIN;
      end

      tcsw_pkg::ST_READ: begin
        ram_re        = 1'b1;
        ram_raddr     = AW'(idx_q);
        res_rd_d      = 1'b1;
        res_inrange_d = (32'(idx_q) < 32'(CELLS));
        res_addr_d    = idx_q;
        state_d       = tcsw_pkg::ST_FIN;
      end

      tcsw_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_written_d  = res_written_q;
          out_addr_d     = res_addr_q;
          out_data_d     = res_rd_q ? (res_inrange_q ? ram_rdata : '0) : res_data_q;
          out_scrolled_d = res_scrolled_q;
          out_row_d      = tcsw_pkg::OROW_W'(row_q);
          out_col_d      = tcsw_pkg::OCOL_W'(col_q);
          state_d        = tcsw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcsw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcsw_pkg::ST_INIT;
      ctr_q       <= '0;
      row_q       <= RW'(1);
      col_q       <= '0;
      wen_q       <= 1'b0;
      wcopy_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      wen_q       <= wen_d;
      wcopy_q     <= wcopy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q           <= ch_d;
    idx_q          <= idx_d;
    res_written_q  <= res_written_d;
    res_scrolled_q <= res_scrolled_d;
    res_rd_q       <= res_rd_d;
    res_inrange_q  <= res_inrange_d;
    res_addr_q     <= res_addr_d;
    res_data_q     <= res_data_d;
    waddr_q        <= waddr_d;
    wdata_q        <= wdata_d;
    out_written_q  <= out_written_d;
    out_addr_q     <= out_addr_d;
    out_data_q     <= out_data_d;
    out_scrolled_q <= out_scrolled_d;
    out_row_q      <= out_row_d;
    out_col_q      <= out_col_d;
  end

  assign out_valid_o    = out_valid_q;
  assign cell_written_o = out_written_q;
  assign cell_addr_o    = out_addr_q;
  assign cell_data_o    = out_data_q;
  assign scrolled_o     = out_scrolled_q;
  assign cursor_row_o   = out_row_q;
  assign cursor_col_o   = out_col_q;

endmodule

[sv/tcsw_screen_ram.sv]
// Screen cell store: one write port, one read port with registered read data.
module tcsw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
